>>> hdl/amos_pkg.sv
// ----------------------------------------------------------------------------
// amos_pkg
// Shared types, widths and constants of the agent motion and overlap step.
// ----------------------------------------------------------------------------
package amos_pkg;

  localparam int unsigned MAX_AGENTS = 16;
  localparam int unsigned FRAC_BITS  = 8;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned START_W    = 20;
  localparam int unsigned VEL_W      = 10;
  localparam int unsigned RAD_W      = 9;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned AREA_W     = 12;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned NCNT_W     = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned RADM_W     = RAD_W + SCALE_W;
  localparam int unsigned PROD_W     = GAIN_W + VEL_W;

  localparam logic [CNT_W-1:0]          AGENT_COUNT_RST  = 5'd16;
  localparam logic signed [GAIN_W-1:0]  SPEED_GAIN_RST   = 12'sd256;
  localparam logic [SCALE_W-1:0]        RADIUS_SCALE_RST = 10'd200;
  localparam logic [AREA_W-1:0]         AREA_WIDTH_RST   = 12'd640;
  localparam logic [AREA_W-1:0]         AREA_HEIGHT_RST  = 12'd480;
  localparam logic                      WRAP_ENABLE_RST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AGENT_COUNT  = 3'd0,
    REG_SPEED_GAIN   = 3'd1,
    REG_RADIUS_SCALE = 3'd2,
    REG_AREA_WIDTH   = 3'd3,
    REG_AREA_HEIGHT  = 3'd4,
    REG_WRAP_ENABLE  = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } amos_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_MOVE_WAIT,
    ST_PAIR,
    ST_PAIR_WAIT,
    ST_EMIT
  } amos_state_e;

  typedef struct packed {
    logic [CNT_W-1:0]         agent_count;
    logic signed [GAIN_W-1:0] speed_gain;
    logic [SCALE_W-1:0]       radius_scale;
    logic [AREA_W-1:0]        area_width;
    logic [AREA_W-1:0]        area_height;
    logic                     wrap_enable;
  } amos_cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic [RAD_W-1:0]        br;
  } agent_rec_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic [MASK_W-1:0]       neighbor_mask;
    logic [NCNT_W-1:0]       neighbor_count;
    logic                    last;
  } amos_res_t;

  typedef struct packed {
    logic load_wr;
    logic clr_i;
    logic inc_i;
    logic clr_j;
    logic inc_j;
    logic issue_mv;
    logic issue_pair;
    logic clr_row;
    logic emit;
  } amos_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic i_last;
    logic j_last;
    logic busy;
    logic out_free;
  } amos_sts_t;

endpackage

>>> hdl/amos_in_if.sv
// ----------------------------------------------------------------------------
// amos_in_if
// Input channel: load and step items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface amos_in_if import amos_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [IDX_W-1:0]         agent_index;
  logic [START_W-1:0]       start_x;
  logic [START_W-1:0]       start_y;
  logic signed [VEL_W-1:0]  vel_x;
  logic signed [VEL_W-1:0]  vel_y;
  logic [RAD_W-1:0]         base_radius;

  modport source (
    output valid, command, agent_index, start_x, start_y, vel_x, vel_y, base_radius,
    input  ready
  );

  modport sink (
    input  valid, command, agent_index, start_x, start_y, vel_x, vel_y, base_radius,
    output ready
  );

endinterface

>>> hdl/amos_out_if.sv
// ----------------------------------------------------------------------------
// amos_out_if
// Output channel: one agent result per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface amos_out_if import amos_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_index;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic [MASK_W-1:0]       neighbor_mask;
  logic [NCNT_W-1:0]       neighbor_count;
  logic                    last;

  modport source (
    output valid, out_index, out_x, out_y, neighbor_mask, neighbor_count, last,
    input  ready
  );

  modport sink (
    input  valid, out_index, out_x, out_y, neighbor_mask, neighbor_count, last,
    output ready
  );

endinterface

>>> hdl/agent_motion_overlap_step.sv
// ----------------------------------------------------------------------------
// agent_motion_overlap_step
// Moves up to MaxAgents circles per step and reports pairwise overlaps.
//
//   channel  | dir | transaction
//   ---------+-----+-----------------------------------------------------
//   req_i    | in  | load one agent record, or step all active agents
//   rsp_o    | out | one result per active agent, last on the final one
//   cfg_*_i  | in  | register write, no read-back
//
// loads are taken while idle. a step tests one pair a cycle through the
// pipelined overlap test on the agent memory's two read ports, drained
// once per agent row. reset restores the register defaults; agent records
// are undefined until loaded. a new item is taken while the last result
// still waits in the output register; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module agent_motion_overlap_step import amos_pkg::*; #(
  parameter int unsigned MaxAgents = MAX_AGENTS,
  parameter int unsigned FracBits  = FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  amos_in_if.sink               req_i,
  amos_out_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [CNT_W-1:0]         agent_count_q;
  logic signed [GAIN_W-1:0] speed_gain_q;
  logic [SCALE_W-1:0]       radius_scale_q;
  logic [AREA_W-1:0]        area_width_q;
  logic [AREA_W-1:0]        area_height_q;
  logic                     wrap_enable_q;

  amos_cfg_t  cfg;
  amos_cmd_t  cmd;
  amos_sts_t  sts;
  agent_rec_t ld_rec;
  amos_res_t  res;
  logic       in_ready;
  logic       out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agent_count_q  <= AGENT_COUNT_RST;
      speed_gain_q   <= SPEED_GAIN_RST;
      radius_scale_q <= RADIUS_SCALE_RST;
      area_width_q   <= AREA_WIDTH_RST;
      area_height_q  <= AREA_HEIGHT_RST;
      wrap_enable_q  <= WRAP_ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AGENT_COUNT:  agent_count_q  <= cfg_wdata_i[CNT_W-1:0];
        REG_SPEED_GAIN:   speed_gain_q   <= signed'(cfg_wdata_i[GAIN_W-1:0]);
        REG_RADIUS_SCALE: radius_scale_q <= cfg_wdata_i[SCALE_W-1:0];
        REG_AREA_WIDTH:   area_width_q   <= cfg_wdata_i[AREA_W-1:0];
        REG_AREA_HEIGHT:  area_height_q  <= cfg_wdata_i[AREA_W-1:0];
        REG_WRAP_ENABLE:  wrap_enable_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.agent_count  = agent_count_q;
  assign cfg.speed_gain   = speed_gain_q;
  assign cfg.radius_scale = radius_scale_q;
  assign cfg.area_width   = area_width_q;
  assign cfg.area_height  = area_height_q;
  assign cfg.wrap_enable  = wrap_enable_q;

  assign ld_rec.x  = signed'(POS_W'(req_i.start_x));
  assign ld_rec.y  = signed'(POS_W'(req_i.start_y));
  assign ld_rec.vx = req_i.vel_x;
  assign ld_rec.vy = req_i.vel_y;
  assign ld_rec.br = req_i.base_radius;

  amos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.command),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  amos_datapath #(
    .MaxAgents (MaxAgents),
    .FracBits  (FracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ld_index_i  (req_i.agent_index),
    .ld_rec_i    (ld_rec),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .out_o       (res)
  );

  assign req_i.ready          = in_ready;
  assign rsp_o.valid          = out_valid;
  assign rsp_o.out_index      = res.out_index;
  assign rsp_o.out_x          = res.out_x;
  assign rsp_o.out_y          = res.out_y;
  assign rsp_o.neighbor_mask  = res.neighbor_mask;
  assign rsp_o.neighbor_count = res.neighbor_count;
  assign rsp_o.last           = res.last;

endmodule

>>> hdl/amos_ctrl.sv
// ----------------------------------------------------------------------------
// amos_ctrl
// Sequencer: load, move sweep, pair-test rows and per-agent result emission.
// ----------------------------------------------------------------------------
module amos_ctrl import amos_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_op_i,
  output logic      in_ready_o,
  input  amos_sts_t sts_i,
  output amos_cmd_t cmd_o
);

  amos_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_op_i == CMD_STEP && !sts_i.n_zero) begin
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (sts_i.i_last) begin
          state_d = ST_MOVE_WAIT;
        end
      end
      ST_MOVE_WAIT: begin
        if (!sts_i.busy) begin
          state_d = ST_PAIR;
        end
      end
      ST_PAIR: begin
        if (sts_i.j_last) begin
          state_d = ST_PAIR_WAIT;
        end
      end
      ST_PAIR_WAIT: begin
        if (!sts_i.busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.i_last ? ST_IDLE : ST_PAIR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == CMD_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.clr_i = 1'b1;
          end
        end
      end
      ST_MOVE: begin
        cmd_o.issue_mv = 1'b1;
        if (sts_i.i_last) begin
          cmd_o.clr_i = 1'b1;
        end else begin
          cmd_o.inc_i = 1'b1;
        end
      end
      ST_MOVE_WAIT: begin
        cmd_o.clr_j   = 1'b1;
        cmd_o.clr_row = 1'b1;
      end
      ST_PAIR: begin
        cmd_o.issue_pair = 1'b1;
        if (!sts_i.j_last) begin
          cmd_o.inc_j = 1'b1;
        end
      end
      ST_PAIR_WAIT: begin
        cmd_o = '0;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.i_last) begin
            cmd_o.inc_i   = 1'b1;
            cmd_o.clr_j   = 1'b1;
            cmd_o.clr_row = 1'b1;
          end
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> hdl/amos_datapath.sv
// ----------------------------------------------------------------------------
// amos_datapath
// Agent memory, move pipeline, pipelined pair overlap test, result register.
// ----------------------------------------------------------------------------
module amos_datapath import amos_pkg::*; #(
  parameter int unsigned MaxAgents = MAX_AGENTS,
  parameter int unsigned FracBits  = FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  amos_cfg_t        cfg_i,
  input  amos_cmd_t        cmd_i,
  output amos_sts_t        sts_o,
  input  logic [IDX_W-1:0] ld_index_i,
  input  agent_rec_t       ld_rec_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output amos_res_t        out_o
);

  localparam int unsigned AW     = $clog2(MaxAgents);
  localparam int unsigned NW     = $clog2(MaxAgents + 1);
  localparam int unsigned RS_W   = RADM_W + 1;
  localparam int unsigned SQ_W   = 2 * POS_W;
  localparam int unsigned DIST_W = SQ_W + 1;
  localparam logic signed [POS_W:0] PosMax = {2'b00, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W:0] PosMin = {2'b11, {(POS_W-1){1'b0}}};

  // position + floor(gain * vel / 2^frac), saturated, then wrapped at the edge if wrap is set
  function automatic logic signed [POS_W-1:0] move_coord(
    input logic signed [POS_W-1:0]  pos,
    input logic signed [PROD_W-1:0] prod,
    input logic [AREA_W-1:0]        span,
    input logic                     wrap
  );
    logic signed [PROD_W-1:0] dlt;
    logic signed [POS_W:0]    sum;
    logic signed [POS_W-1:0]  sat;
    logic [POS_W:0]           lim_w;
    logic [POS_W-1:0]         lim;
    logic signed [POS_W-1:0]  res;
    dlt   = prod >>> FracBits;
    sum   = (POS_W+1)'(pos) + (POS_W+1)'(dlt);
    if (sum > PosMax) begin
      sat = PosMax[POS_W-1:0];
    end else if (sum < PosMin) begin
      sat = PosMin[POS_W-1:0];
    end else begin
      sat = sum[POS_W-1:0];
    end
    lim_w = (POS_W+1)'(span) << FracBits;
    lim   = (lim_w[POS_W] | lim_w[POS_W-1]) ? PosMax[POS_W-1:0] : lim_w[POS_W-1:0];
    res   = sat;
    if (wrap) begin
      if (sat[POS_W-1]) begin
        res = signed'(lim);
      end else if ($unsigned(sat) > lim) begin
        res = '0;
      end
    end
    return res;
  endfunction

  function automatic logic [POS_W-1:0] abs_diff(
    input logic signed [POS_W-1:0] a,
    input logic signed [POS_W-1:0] b
  );
    logic signed [POS_W:0] d;
    logic signed [POS_W:0] m;
    d = (POS_W+1)'(a) - (POS_W+1)'(b);
    m = d[POS_W] ? -d : d;
    return m[POS_W-1:0];
  endfunction

  agent_rec_t agent_mem_q [MaxAgents];
  agent_rec_t rec_a_q, rec_b_q;

  logic [AW-1:0] i_q, j_q;
  logic [NW-1:0] n;

  logic          s1_vld_q, s1_mv_q;
  logic [AW-1:0] s1_tag_q;

  logic                     mv_vld_q;
  logic [AW-1:0]            mv_idx_q;
  agent_rec_t               mv_rec_q;
  logic signed [PROD_W-1:0] mv_prod_x_q, mv_prod_y_q;
  agent_rec_t               mv_new;

  logic              p2_vld_q, p3_vld_q, p4_vld_q;
  logic [AW-1:0]     p2_tag_q, p3_tag_q, p4_tag_q;
  logic [POS_W-1:0]  dx_q, dy_q;
  logic [RADM_W-1:0] rad_a_q, rad_b_q;
  logic [SQ_W-1:0]   dx2_q, dy2_q;
  logic [RS_W-1:0]   rs_q;
  logic [DIST_W-1:0] dist_q;
  logic [2*RS_W-1:0] rs2_q;
  logic              hit;

  logic [MaxAgents-1:0] mask_q;
  logic [NCNT_W-1:0]    cnt_q;
  logic                 ld_ok;
  logic [AW-1:0]        ld_addr;

  logic      out_valid_q;
  amos_res_t out_q;

  assign n = (32'(cfg_i.agent_count) > MaxAgents) ? NW'(MaxAgents) : NW'(cfg_i.agent_count);

  assign ld_ok   = 32'(ld_index_i) < MaxAgents;
  assign ld_addr = AW'(ld_index_i);

  assign sts_o.n_zero   = (cfg_i.agent_count == '0);
  assign sts_o.i_last   = (NW'(i_q) + NW'(1)) == n;
  assign sts_o.j_last   = (NW'(j_q) + NW'(1)) == n;
  assign sts_o.busy     = s1_vld_q | mv_vld_q | p2_vld_q | p3_vld_q | p4_vld_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // agent memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && ld_ok) begin
      agent_mem_q[ld_addr] <= ld_rec_i;
    end else if (mv_vld_q) begin
      agent_mem_q[mv_idx_q] <= mv_new;
    end
    rec_a_q <= agent_mem_q[i_q];
    rec_b_q <= agent_mem_q[j_q];
  end

  always_comb begin
    mv_new   = mv_rec_q;
    mv_new.x = move_coord(mv_rec_q.x, mv_prod_x_q, cfg_i.area_width, cfg_i.wrap_enable);
    mv_new.y = move_coord(mv_rec_q.y, mv_prod_y_q, cfg_i.area_height, cfg_i.wrap_enable);
  end

  // self pairs are tested but never counted
  assign hit = p4_vld_q && (dist_q < DIST_W'(rs2_q)) && (p4_tag_q != i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      s1_vld_q    <= 1'b0;
      s1_mv_q     <= 1'b0;
      mv_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_vld_q    <= 1'b0;
      p4_vld_q    <= 1'b0;
      mask_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_i) begin
        i_q <= '0;
      end else if (cmd_i.inc_i) begin
        i_q <= i_q + AW'(1);
      end
      if (cmd_i.clr_j) begin
        j_q <= '0;
      end else if (cmd_i.inc_j) begin
        j_q <= j_q + AW'(1);
      end
      s1_vld_q <= cmd_i.issue_mv | cmd_i.issue_pair;
      s1_mv_q  <= cmd_i.issue_mv;
      mv_vld_q <= s1_vld_q & s1_mv_q;
      p2_vld_q <= s1_vld_q & ~s1_mv_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      if (cmd_i.clr_row) begin
        mask_q <= '0;
        cnt_q  <= '0;
      end else if (hit) begin
        mask_q[p4_tag_q] <= 1'b1;
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + NCNT_W'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= cmd_i.issue_mv ? i_q : j_q;
    // move stage
    mv_idx_q    <= s1_tag_q;
    mv_rec_q    <= rec_a_q;
    mv_prod_x_q <= PROD_W'(cfg_i.speed_gain) * PROD_W'(rec_a_q.vx);
    mv_prod_y_q <= PROD_W'(cfg_i.speed_gain) * PROD_W'(rec_a_q.vy);
    // pair test stages
    p2_tag_q <= s1_tag_q;
    dx_q     <= abs_diff(rec_a_q.x, rec_b_q.x);
    dy_q     <= abs_diff(rec_a_q.y, rec_b_q.y);
    rad_a_q  <= RADM_W'(rec_a_q.br) * RADM_W'(cfg_i.radius_scale);
    rad_b_q  <= RADM_W'(rec_b_q.br) * RADM_W'(cfg_i.radius_scale);
    p3_tag_q <= p2_tag_q;
    dx2_q    <= SQ_W'(dx_q) * SQ_W'(dx_q);
    dy2_q    <= SQ_W'(dy_q) * SQ_W'(dy_q);
    rs_q     <= RS_W'(rad_a_q) + RS_W'(rad_b_q);
    p4_tag_q <= p3_tag_q;
    dist_q   <= DIST_W'(dx2_q) + DIST_W'(dy2_q);
    rs2_q    <= (2*RS_W)'(rs_q) * (2*RS_W)'(rs_q);
    if (cmd_i.emit) begin
      out_q.out_index      <= IDX_W'(i_q);
      out_q.out_x          <= rec_a_q.x;
      out_q.out_y          <= rec_a_q.y;
      out_q.neighbor_mask  <= MASK_W'(mask_q);
      out_q.neighbor_count <= cnt_q;
      out_q.last           <= sts_o.i_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> bench/amos_step_checker.sv
// ----------------------------------------------------------------------------
// amos_step_checker
// Watches the request, response and register-write ports of the agent motion
// and overlap step. It keeps its own copy of the agent records and the
// registers, works out every agent result that a step must produce, and
// compares each response transaction field by field with the oldest result
// still due.
// ----------------------------------------------------------------------------
module amos_step_checker import amos_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  amos_in_if                    req_i,
  amos_out_if                   rsp_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  localparam longint POS_HI = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_LO = -(longint'(1) << (POS_W - 1));

  amos_cfg_t               regs;
  logic signed [POS_W-1:0] pos_x  [MAX_AGENTS];
  logic signed [POS_W-1:0] pos_y  [MAX_AGENTS];
  logic signed [VEL_W-1:0] vel_x  [MAX_AGENTS];
  logic signed [VEL_W-1:0] vel_y  [MAX_AGENTS];
  logic [RAD_W-1:0]        base_r [MAX_AGENTS];
  amos_res_t               due_results [$];

  // one coordinate: scaled velocity floored, saturated, then wrapped if enabled
  function automatic logic signed [POS_W-1:0] move_coord(
    input logic signed [POS_W-1:0] p,
    input logic signed [VEL_W-1:0] v,
    input logic [AREA_W-1:0]       span
  );
    longint q;
    longint lim;
    q = longint'(p) + ((longint'(regs.speed_gain) * longint'(v)) >>> FRAC_BITS);
    if (q > POS_HI) begin
      q = POS_HI;
    end else if (q < POS_LO) begin
      q = POS_LO;
    end
    if (regs.wrap_enable) begin
      lim = longint'(span) << FRAC_BITS;
      if (lim > POS_HI) begin
        lim = POS_HI;
      end
      if (q < 0) begin
        q = lim;
      end else if (q > lim) begin
        q = 0;
      end
    end
    return q[POS_W-1:0];
  endfunction

  task automatic step_agents();
    int unsigned           n;
    int unsigned           cnt;
    longint                d;
    longint unsigned       dx;
    longint unsigned       dy;
    longint unsigned       rs;
    longint unsigned       rad  [MAX_AGENTS];
    logic [MAX_AGENTS-1:0] hits [MAX_AGENTS];
    amos_res_t             r;
    n = (regs.agent_count > MAX_AGENTS) ? MAX_AGENTS : regs.agent_count;
    for (int i = 0; i < MAX_AGENTS; i++) begin
      hits[i] = '0;
      rad[i]  = longint'(base_r[i]) * longint'(regs.radius_scale);
    end
    for (int i = 0; i < n; i++) begin
      pos_x[i] = move_coord(pos_x[i], vel_x[i], regs.area_width);
      pos_y[i] = move_coord(pos_y[i], vel_y[i], regs.area_height);
    end
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        d  = longint'(pos_x[i]) - longint'(pos_x[j]);
        dx = (d < 0) ? -d : d;
        d  = longint'(pos_y[i]) - longint'(pos_y[j]);
        dy = (d < 0) ? -d : d;
        rs = rad[i] + rad[j];
        if (dx * dx + dy * dy < rs * rs) begin
          hits[i][j] = 1'b1;
          hits[j][i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      cnt = $countones(hits[i]);
      if (cnt > 15) begin
        cnt = 15;
      end
      r.out_index      = IDX_W'(i);
      r.out_x          = pos_x[i];
      r.out_y          = pos_y[i];
      r.neighbor_mask  = hits[i][MASK_W-1:0];
      r.neighbor_count = NCNT_W'(cnt);
      r.last           = (i == n - 1);
      due_results = {due_results, r};
      pending_o++;
    end
  endtask

  task automatic compare_result();
    amos_res_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result transaction for agent %0d", rsp_i.out_index);
      mismatches_o++;
      return;
    end
    want = due_results.pop_front();
    pending_o--;
    if (rsp_i.out_index !== want.out_index) begin
      $error("out_index: expected %0d, got %0d", want.out_index, rsp_i.out_index);
      mismatches_o++;
    end
    if (rsp_i.out_x !== want.out_x) begin
      $error("out_x: expected %0d, got %0d", want.out_x, rsp_i.out_x);
      mismatches_o++;
    end
    if (rsp_i.out_y !== want.out_y) begin
      $error("out_y: expected %0d, got %0d", want.out_y, rsp_i.out_y);
      mismatches_o++;
    end
    if (rsp_i.neighbor_mask !== want.neighbor_mask) begin
      $error("neighbor_mask: expected %h, got %h", want.neighbor_mask, rsp_i.neighbor_mask);
      mismatches_o++;
    end
    if (rsp_i.neighbor_count !== want.neighbor_count) begin
      $error("neighbor_count: expected %0d, got %0d", want.neighbor_count,
             rsp_i.neighbor_count);
      mismatches_o++;
    end
    if (rsp_i.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, rsp_i.last);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{AGENT_COUNT_RST, SPEED_GAIN_RST, RADIUS_SCALE_RST,
               AREA_WIDTH_RST, AREA_HEIGHT_RST, WRAP_ENABLE_RST};
      due_results.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_AGENT_COUNT:  regs.agent_count  = cfg_wdata_i[CNT_W-1:0];
          REG_SPEED_GAIN:   regs.speed_gain   = cfg_wdata_i[GAIN_W-1:0];
          REG_RADIUS_SCALE: regs.radius_scale = cfg_wdata_i[SCALE_W-1:0];
          REG_AREA_WIDTH:   regs.area_width   = cfg_wdata_i[AREA_W-1:0];
          REG_AREA_HEIGHT:  regs.area_height  = cfg_wdata_i[AREA_W-1:0];
          REG_WRAP_ENABLE:  regs.wrap_enable  = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.command == CMD_LOAD) begin
          pos_x[req_i.agent_index]  = POS_W'(req_i.start_x);
          pos_y[req_i.agent_index]  = POS_W'(req_i.start_y);
          vel_x[req_i.agent_index]  = req_i.vel_x;
          vel_y[req_i.agent_index]  = req_i.vel_y;
          base_r[req_i.agent_index] = req_i.base_radius;
        end else begin
          step_agents();
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        compare_result();
      end
    end
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the agent motion and overlap step: loads every agent slot,
// runs steps under the reset registers, drives two agents outward with
// wrapping off, then walks through a series of register settings with random
// loads and steps. Both handshake sides idle at random, but for one calm
// phase; the amos_step_checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import amos_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned IDLE_PCT      = 14;
  localparam int unsigned STEP_PCT      = 40;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 29;
  localparam int unsigned CALM_PHASE    = 7;
  localparam int unsigned DRIFT_STEPS   = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    pending;
  bit                    calm;
  amos_cfg_t             cur;

  amos_in_if  req ();
  amos_out_if rsp ();

  agent_motion_overlap_step DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  amos_step_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .rsp_i        (rsp),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_item(
    input amos_op_e                op,
    input logic [IDX_W-1:0]        idx,
    input logic [START_W-1:0]      sx,
    input logic [START_W-1:0]      sy,
    input logic signed [VEL_W-1:0] vx,
    input logic signed [VEL_W-1:0] vy,
    input logic [RAD_W-1:0]        br
  );
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.command     <= op;
    req.agent_index <= idx;
    req.start_x     <= sx;
    req.start_y     <= sy;
    req.vel_x       <= vx;
    req.vel_y       <= vy;
    req.base_radius <= br;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic step_all();
    send_item(CMD_STEP, IDX_W'($urandom), START_W'($urandom), START_W'($urandom),
              VEL_W'($urandom), VEL_W'($urandom), RAD_W'($urandom));
  endtask

  task automatic load_rand();
    logic [START_W-1:0] sx;
    logic [START_W-1:0] sy;
    // mostly inside the wrap area, where neighbors are likely
    if ($urandom_range(9) < 7) begin
      sx = START_W'($urandom_range(0, 32'(cur.area_width) << FRAC_BITS));
      sy = START_W'($urandom_range(0, 32'(cur.area_height) << FRAC_BITS));
    end else begin
      sx = START_W'($urandom);
      sy = START_W'($urandom);
    end
    send_item(CMD_LOAD, IDX_W'($urandom_range(0, MAX_AGENTS - 1)), sx, sy,
              VEL_W'($urandom), VEL_W'($urandom), RAD_W'($urandom));
  endtask

  // hold requests until every due result has been taken
  task automatic drain();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input amos_cfg_t c);
    drain();
    // a step with no active agent gives nothing to wait for
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    put_reg(REG_AGENT_COUNT, CFG_DATA_W'(c.agent_count));
    put_reg(REG_SPEED_GAIN, c.speed_gain);
    put_reg(REG_RADIUS_SCALE, CFG_DATA_W'(c.radius_scale));
    put_reg(REG_AREA_WIDTH, c.area_width);
    put_reg(REG_AREA_HEIGHT, c.area_height);
    put_reg(REG_WRAP_ENABLE, CFG_DATA_W'(c.wrap_enable));
    cfg_we <= 1'b0;
    cur = c;
  endtask

  function automatic amos_cfg_t phase_setting(input int unsigned p);
    amos_cfg_t c;
    c.agent_count  = CNT_W'($urandom_range(1, MAX_AGENTS));
    c.speed_gain   = GAIN_W'(int'($urandom_range(0, 2560)) - 1280);
    c.radius_scale = SCALE_W'($urandom_range(30, 800));
    c.area_width   = AREA_W'($urandom_range(1, 4095));
    c.area_height  = AREA_W'($urandom_range(1, 4095));
    c.wrap_enable  = 1'($urandom_range(0, 1));
    case (p)
      0: c = '{5'd16, 12'h7ff, 10'h3ff, 12'hfff, 12'hfff, 1'b1};
      // single agent in a zero-size area
      1: c = '{5'd1, 12'h800, 10'd0, 12'd0, 12'd0, 1'b1};
      2: c.agent_count = '0;
      // count above the agent table, no motion
      3: c = '{5'd31, 12'h000, 10'd512, 12'd1, 12'd1, 1'b1};
      4: c.agent_count = 5'd17;
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    rst_ni          = 1'b0;
    calm            = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    req.valid       = 1'b0;
    req.command     = CMD_LOAD;
    req.agent_index = '0;
    req.start_x     = '0;
    req.start_y     = '0;
    req.vel_x       = '0;
    req.vel_y       = '0;
    req.base_radius = '0;
    cur = '{AGENT_COUNT_RST, SPEED_GAIN_RST, RADIUS_SCALE_RST,
            AREA_WIDTH_RST, AREA_HEIGHT_RST, WRAP_ENABLE_RST};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every slot gets a record before any step reads it
    send_item(CMD_LOAD, IDX_W'(0), '0, '0, VEL_W'(-512), VEL_W'(-512), '0);
    send_item(CMD_LOAD, IDX_W'(1), '1, '1, VEL_W'(511), VEL_W'(511), RAD_W'(511));
    for (int i = 2; i < MAX_AGENTS; i++) begin
      send_item(CMD_LOAD, IDX_W'(i),
                START_W'((320 << FRAC_BITS) + $urandom_range(0, 8191)),
                START_W'((240 << FRAC_BITS) + $urandom_range(0, 8191)),
                VEL_W'(int'($urandom_range(0, 64)) - 32),
                VEL_W'(int'($urandom_range(0, 64)) - 32),
                RAD_W'($urandom_range(0, 256)));
    end
    // reset registers: both corner agents wrap
    step_all();
    step_all();

    // drift two agents out of the area, past both edges, with wrapping off
    program_regs('{5'd2, 12'h7ff, 10'd800, 12'hfff, 12'hfff, 1'b0});
    send_item(CMD_LOAD, IDX_W'(0), '1, '0, VEL_W'(511), VEL_W'(-512), RAD_W'(256));
    send_item(CMD_LOAD, IDX_W'(1), '0, '1, VEL_W'(-512), VEL_W'(511), RAD_W'(256));
    repeat (DRIFT_STEPS) step_all();
    // drifted coordinates fold back once wrapping returns
    program_regs('{5'd2, 12'h100, 10'd200, 12'd640, 12'd480, 1'b1});
    step_all();
    step_all();

    for (int unsigned p = 0; p < PHASES; p++) begin
      program_regs(phase_setting(p));
      calm <= (p == CALM_PHASE);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          drain();
        end
        if ($urandom_range(99) < STEP_PCT) begin
          step_all();
        end else begin
          load_rand();
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/amos_pkg.sv
hdl/amos_in_if.sv
hdl/amos_out_if.sv
hdl/amos_ctrl.sv
hdl/amos_datapath.sv
hdl/agent_motion_overlap_step.sv
bench/amos_step_checker.sv
bench/testbench.sv
